// ===== hdl/sld_pkg.sv =====
// package for the sync/length/checksum deframer
// frame constants, phase and status codes, config struct; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sld_pkg;

  localparam logic [7:0] SyncFirst  = 8'hC6;
  localparam logic [7:0] SyncSecond = 8'hA2;
  localparam logic [7:0] SyncSum    = 8'(SyncFirst + SyncSecond);

  // the enable mask has one bit per command below this value
  localparam int unsigned MaskBits = 32;

  // register indexes on the configuration port
  localparam logic RegCommandLimit = 1'b0;
  localparam logic RegHandlerMask  = 1'b1;

  typedef enum logic [4:0] {
    PH_SYNC1    = 5'b00001,
    PH_SYNC2    = 5'b00010,
    PH_LENGTH   = 5'b00100,
    PH_PAYLOAD  = 5'b01000,
    PH_CHECKSUM = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    ST_DELIVERED  = 2'd0,
    ST_BAD_SUM    = 2'd1,
    ST_CMD_RANGE  = 2'd2,
    ST_NO_HANDLER = 2'd3
  } status_t;

  typedef struct packed {
    logic [5:0]  command_limit;
    logic [31:0] handler_enable_mask;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hdl/sld_chan_if.sv =====
// valid/ready channels of the deframer: received byte beats in, result beats out
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
interface sld_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sld_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic [6:0] position;
  logic [7:0] frame_length;
  logic       last;
  logic [1:0] frame_status;

  modport source (output valid, output data_byte, output position, output frame_length,
                  output last, output frame_status, input ready);
  modport sink   (input valid, input data_byte, input position, input frame_length,
                  input last, input frame_status, output ready);
endinterface
`default_nettype wire

// ===== hdl/sld_cfg_regs.sv =====
// apb register file: command limit and handler enable mask
// depends on sld_pkg
`timescale 1ns / 1ps
`default_nettype none
module sld_cfg_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  output sld_pkg::cfg_t     cfg
);
  import sld_pkg::*;

  logic       wr_en;
  logic       reg_sel;
  logic [5:0] command_limit;
  logic [31:0] handler_enable_mask;

  // low address bits are the byte offset within a word
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      command_limit       <= 6'd32;
      handler_enable_mask <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegCommandLimit: command_limit       <= pwdata[5:0];
        RegHandlerMask:  handler_enable_mask <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegCommandLimit: prdata = {26'd0, command_limit};
      RegHandlerMask:  prdata = handler_enable_mask;
      default:         prdata = '0;
    endcase
  end

  assign cfg.command_limit       = command_limit;
  assign cfg.handler_enable_mask = handler_enable_mask;

endmodule
`default_nettype wire

// ===== hdl/sld_parser.sv =====
// frame parser: input register, phase machine with running sum, result register
// depends on sld_pkg and sld_chan_if
`timescale 1ns / 1ps
`default_nettype none
module sld_parser #(
  parameter int unsigned MAX_PAYLOAD   = 128,
  parameter int unsigned COMMAND_SLOTS = 32
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire sld_pkg::cfg_t cfg,
  sld_byte_if.sink      rx,
  sld_result_if.source  res
);
  import sld_pkg::*;

  localparam logic [8:0] MaxLen = 9'(MAX_PAYLOAD);
  localparam logic [6:0] Slots  = 7'(COMMAND_SLOTS);

  // input register
  logic       in_valid;
  logic [7:0] in_byte;

  // frame state
  phase_t     phase, phase_next;
  logic [7:0] expected_length, expected_length_next;
  logic [7:0] received_count, received_count_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] command_byte, command_byte_next;

  // result register
  logic       out_valid;
  logic [7:0] out_data;
  logic [6:0] out_pos;
  logic [7:0] out_len;
  logic       out_last;
  status_t    out_status;

  logic       advance;
  logic       emit;
  logic [7:0] emit_data;
  logic [6:0] emit_pos;
  logic       emit_last;
  status_t    emit_status;
  logic [7:0] count_inc;
  logic [6:0] limit_eff;
  status_t    end_status;

  // pipeline moves whenever the result register is empty or being drained
  assign advance  = !out_valid || res.ready;
  assign rx.ready = !in_valid || advance;

  assign count_inc = received_count + 8'd1;
  assign limit_eff = ({1'b0, cfg.command_limit} > Slots) ? Slots : {1'b0, cfg.command_limit};

  always_comb begin
    if (~running_sum != in_byte) begin
      end_status = ST_BAD_SUM;
    end else if (command_byte >= {1'b0, limit_eff}) begin
      end_status = ST_CMD_RANGE;
    end else if (command_byte >= 8'(MaskBits)) begin
      end_status = ST_NO_HANDLER;
    end else if (!cfg.handler_enable_mask[command_byte[4:0]]) begin
      end_status = ST_NO_HANDLER;
    end else begin
      end_status = ST_DELIVERED;
    end
  end

  always_comb begin
    phase_next           = phase;
    expected_length_next = expected_length;
    received_count_next  = received_count;
    running_sum_next     = running_sum;
    command_byte_next    = command_byte;
    emit                 = 1'b0;
    emit_data            = in_byte;
    emit_pos             = received_count[6:0];
    emit_last            = 1'b0;
    emit_status          = ST_DELIVERED;
    unique case (phase)
      PH_SYNC2: begin
        if (in_byte == SyncSecond) begin
          running_sum_next = SyncSum;
          phase_next       = PH_LENGTH;
        end else begin
          phase_next = PH_SYNC1;
        end
      end
      PH_LENGTH: begin
        if (in_byte == 8'd0 || {1'b0, in_byte} > MaxLen) begin
          phase_next = PH_SYNC1;
        end else begin
          expected_length_next = in_byte;
          received_count_next  = 8'd0;
          running_sum_next     = running_sum + in_byte;
          phase_next           = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        if (received_count == 8'd0) begin
          command_byte_next = in_byte;
        end
        running_sum_next    = running_sum + in_byte;
        emit                = 1'b1;
        received_count_next = count_inc;
        if (count_inc >= expected_length) begin
          phase_next = PH_CHECKSUM;
        end
      end
      PH_CHECKSUM: begin
        emit        = 1'b1;
        emit_data   = command_byte;
        emit_pos    = 7'd0;
        emit_last   = 1'b1;
        emit_status = end_status;
        phase_next  = PH_SYNC1;
      end
      default: begin
        phase_next = (in_byte == SyncFirst) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (rx.ready) begin
      in_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready) begin
      in_byte <= rx.rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_SYNC1;
      expected_length <= '0;
      received_count  <= '0;
      running_sum     <= '0;
      command_byte    <= '0;
      out_valid       <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && emit;
      if (in_valid) begin
        phase           <= phase_next;
        expected_length <= expected_length_next;
        received_count  <= received_count_next;
        running_sum     <= running_sum_next;
        command_byte    <= command_byte_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && emit) begin
      out_data   <= emit_data;
      out_pos    <= emit_pos;
      out_len    <= expected_length;
      out_last   <= emit_last;
      out_status <= emit_status;
    end
  end

  assign res.valid        = out_valid;
  assign res.data_byte    = out_data;
  assign res.position     = out_pos;
  assign res.frame_length = out_len;
  assign res.last         = out_last;
  assign res.frame_status = out_status;

endmodule
`default_nettype wire

// ===== hdl/sync_length_checksum_deframer.sv =====
// top level of the frame deframer: apb registers plus the frame parser
// depends on sld_pkg, sld_chan_if, sld_cfg_regs, sld_parser
//
// frames are 0xC6, 0xA2, length (1..MAX_PAYLOAD), payload, checksum, where the
// checksum is the inverse of the 8-bit sum of the sync bytes, length and payload.
// rx carries one received byte per beat. res carries one beat per payload byte
// (data_byte with its position, last low) and one end beat on the checksum byte
// (command byte, last high, frame_status). a frame's payload beats count only
// when its end beat says delivered; otherwise downstream drops them.
// sync, length and a bad length produce no beat.
// a payload or checksum byte reaches res through the input register, then the
// result register. one byte is taken every cycle unless res stalls, set by the
// phase update and running sum, which both update with each byte taken.
// when res stalls, the result register holds and rx.ready stays high only while
// the input register is empty, so at most one byte waits inside.
// reset clears the phase to sync search, all counters and sums, and the
// registers to command_limit 32 and an empty handler mask.
// configuration is written over apb at byte address 0 (limit) and 4 (mask).
`timescale 1ns / 1ps
`default_nettype none
module sync_length_checksum_deframer #(
  parameter int unsigned MAX_PAYLOAD   = 128,
  parameter int unsigned COMMAND_SLOTS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  sld_byte_if.sink         rx,
  sld_result_if.source     res
);
  import sld_pkg::*;

  cfg_t cfg;

  sld_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sld_parser #(
    .MAX_PAYLOAD   (MAX_PAYLOAD),
    .COMMAND_SLOTS (COMMAND_SLOTS)
  ) u_parser (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .rx  (rx),
    .res (res)
  );

endmodule
`default_nettype wire

// ===== bench/tb_sync_length_checksum_deframer.sv =====
// testbench for the sync/length/checksum deframer: random and directed byte streams
// with a frame predictor and scoreboard; depends on sld_pkg, sld_chan_if and the rtl
`timescale 1ns / 1ps
module tb_sync_length_checksum_deframer;
  import sld_pkg::*;

  localparam int unsigned MaxPayload   = 128;
  localparam int unsigned CommandSlots = 32;
  localparam logic [2:0]  AddrLimit    = {RegCommandLimit, 2'b00};
  localparam logic [2:0]  AddrMask     = {RegHandlerMask, 2'b00};
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned RandomBytes  = 1450;
  localparam int unsigned HoldCycles   = 250;
  localparam int unsigned SettleCycles = 6;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [6:0] position;
    logic [7:0] frame_length;
    logic       last;
    status_t    frame_status;
  } result_t;

  class frame_scoreboard;
    phase_t      phase;
    logic [7:0]  exp_len;
    logic [7:0]  rx_count;
    logic [7:0]  sum;
    logic [7:0]  cmd;
    logic [5:0]  cmd_limit;
    logic [31:0] mask;
    result_t     beats_q[$];
    int unsigned errors;

    function new();
      phase     = PH_SYNC1;
      exp_len   = '0;
      rx_count  = '0;
      sum       = '0;
      cmd       = '0;
      cmd_limit = 6'd32;
      mask      = '0;
      errors    = 0;
    endfunction

    function void set_register(logic [2:0] addr, logic [31:0] value);
      if (addr == AddrLimit) begin
        cmd_limit = value[5:0];
      end else if (addr == AddrMask) begin
        mask = value;
      end
    endfunction

    // bad checksum beats range, range beats missing handler
    function status_t end_status(logic [7:0] rx);
      int unsigned lim;
      lim = (cmd_limit > CommandSlots) ? CommandSlots : cmd_limit;
      if (8'(~sum) != rx) return ST_BAD_SUM;
      if (cmd >= lim) return ST_CMD_RANGE;
      if (cmd >= MaskBits || !mask[cmd[4:0]]) return ST_NO_HANDLER;
      return ST_DELIVERED;
    endfunction

    function void note_byte(logic [7:0] rx);
      result_t r;
      case (phase)
        PH_SYNC2: begin
          // a mismatch is not taken as a new first sync byte
          if (rx == SyncSecond) begin
            sum   = SyncSum;
            phase = PH_LENGTH;
          end else begin
            phase = PH_SYNC1;
          end
        end
        PH_LENGTH: begin
          if (rx == 0 || rx > MaxPayload) begin
            phase = PH_SYNC1;
          end else begin
            exp_len  = rx;
            rx_count = '0;
            sum      = sum + rx;
            phase    = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (rx_count == 0) cmd = rx;
          sum            = sum + rx;
          r.data_byte    = rx;
          r.position     = rx_count[6:0];
          r.frame_length = exp_len;
          r.last         = 1'b0;
          r.frame_status = ST_DELIVERED;
          beats_q.push_back(r);
          rx_count = rx_count + 8'd1;
          if (rx_count >= exp_len) phase = PH_CHECKSUM;
        end
        PH_CHECKSUM: begin
          r.data_byte    = cmd;
          r.position     = '0;
          r.frame_length = exp_len;
          r.last         = 1'b1;
          r.frame_status = end_status(rx);
          beats_q.push_back(r);
          phase = PH_SYNC1;
        end
        default: begin
          phase = (rx == SyncFirst) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (beats_q.size() == 0) begin
        $error("unexpected result beat: data_byte %0h position %0d last %0b",
               got.data_byte, got.position, got.last);
        errors++;
        return;
      end
      want = beats_q.pop_front();
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.position !== want.position) begin
        $error("position: expected %0d, got %0d", want.position, got.position);
        errors++;
      end
      if (got.frame_length !== want.frame_length) begin
        $error("frame_length: expected %0d, got %0d", want.frame_length, got.frame_length);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
      if (got.frame_status !== want.frame_status) begin
        $error("frame_status: expected %0d, got %0d", want.frame_status, got.frame_status);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  wire  [31:0] prdata;
  wire         pready;

  sld_byte_if   rx_if ();
  sld_result_if res_if ();

  sync_length_checksum_deframer #(
    .MAX_PAYLOAD   (MaxPayload),
    .COMMAND_SLOTS (CommandSlots)
  ) u_top (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx_if),
    .res     (res_if)
  );

  frame_scoreboard sb = new();

  int unsigned bytes_sent    = 0;
  int unsigned tx_burst_left = 0;
  bit          tx_gappy      = 1'b0;
  bit          hold_request  = 1'b0;
  int unsigned cycles        = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(16, 96);
      tx_gappy      = ($urandom_range(0, 2) != 0);
    end
    tx_burst_left--;
    gap = tx_gappy ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap != 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (rx_if.ready !== 1'b1) @(posedge clk);
    sb.note_byte(b);
    bytes_sent++;
  endtask

  task automatic end_burst();
    @(negedge clk);
    rx_if.valid <= 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd, input bit bad_sum);
    logic [7:0] sum;
    logic [7:0] b;
    sum = SyncSum + len;
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(len);
    for (int i = 0; i < len; i++) begin
      b   = (i == 0) ? cmd : 8'($urandom);
      sum = sum + b;
      send_byte(b);
    end
    send_byte(bad_sum ? 8'(~sum ^ 8'($urandom_range(1, 255))) : 8'(~sum));
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    sb.set_register(addr, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.beats_q.size() != 0) @(posedge clk);
    // a sync or length byte may still sit in the input register
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic configure(input logic [5:0] limit, input logic [31:0] mask);
    end_burst();
    wait_drained();
    reg_write(AddrLimit, {26'd0, limit});
    reg_write(AddrMask, mask);
  endtask

  task automatic random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned pick;
    logic [7:0]  len;
    logic [7:0]  cmd;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 39))
        0:       len = $urandom_range(0, 1) ? 8'(MaxPayload) : 8'($urandom_range(64, 127));
        1, 2, 3: len = 8'($urandom_range(5, 24));
        default: len = 8'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 9))
        0:       cmd = 8'($urandom_range(32, 255));
        1:       cmd = 8'($urandom_range(32, 63));
        default: cmd = 8'($urandom_range(0, 31));
      endcase
      if (pick < 70) begin
        send_frame(len, cmd, 1'b0);
      end else if (pick < 80) begin
        send_frame(len, cmd, 1'b1);
      end else if (pick < 86) begin
        send_byte(SyncFirst);
        send_byte(SyncSecond);
        send_byte($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom_range(MaxPayload + 1, 255)));
      end else if (pick < 92) begin
        send_byte(SyncFirst);
        send_byte($urandom_range(0, 1) ? SyncFirst : 8'($urandom_range(0, 255)));
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    int unsigned gap;
    int unsigned burst_left;
    bit          gappy;
    result_t     got;
    res_if.ready = 1'b0;
    burst_left   = 0;
    gappy        = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_request) begin
        // long hold so the deframer fills up and stalls rx
        hold_request = 1'b0;
        @(negedge clk);
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end
      if (burst_left == 0) begin
        burst_left = $urandom_range(16, 96);
        gappy      = ($urandom_range(0, 2) != 0);
      end
      burst_left--;
      gap = gappy ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (res_if.valid !== 1'b1) @(posedge clk);
      got.data_byte    = res_if.data_byte;
      got.position     = res_if.position;
      got.frame_length = res_if.frame_length;
      got.last         = res_if.last;
      got.frame_status = status_t'(res_if.frame_status);
      sb.check_result(got);
    end
  end

  initial begin
    rst           = 1'b1;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: handlers for commands 0 and 5 only
    configure(6'd32, 32'h0000_0021);
    send_byte(8'h00);
    send_byte(8'hFF);
    // first sync repeated in place of the second, then a stray second sync
    send_byte(SyncFirst);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    // zero length and one over the maximum
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(8'd0);
    send_byte(SyncFirst);
    send_byte(SyncSecond);
    send_byte(8'(MaxPayload + 1));
    send_frame(8'd1, 8'd0, 1'b0);
    send_frame(8'd1, 8'd1, 1'b0);
    send_frame(8'd2, 8'd5, 1'b1);
    send_frame(8'd1, 8'd40, 1'b0);
    send_frame(8'd1, 8'hFF, 1'b1);

    configure(6'd63, 32'hFFFF_FFFF);
    random_traffic(RandomBytes / 6);
    configure(6'd0, 32'hFFFF_FFFF);
    hold_request = 1'b1;
    random_traffic(RandomBytes / 6);
    configure(6'd32, $urandom);
    random_traffic(RandomBytes / 6);
    configure(6'($urandom_range(0, 63)), $urandom);
    random_traffic(RandomBytes / 6);
    configure(6'd20, 32'h0000_FFFF);
    random_traffic(RandomBytes / 6);
    configure(6'd32, 32'h0000_0000);
    random_traffic(RandomBytes / 6);

    end_burst();
    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.beats_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sync_length_checksum_deframer.f =====
hdl/sld_pkg.sv
hdl/sld_chan_if.sv
hdl/sld_cfg_regs.sv
hdl/sld_parser.sv
hdl/sync_length_checksum_deframer.sv
bench/tb_sync_length_checksum_deframer.sv
